// File: rtl/core/sliding_window_average_core_defines.svh
// assertion macros for the sliding window average core
// used by the top level only; needs nothing else
`ifndef SLIDING_WINDOW_AVERAGE_CORE_DEFINES_SVH
`define SLIDING_WINDOW_AVERAGE_CORE_DEFINES_SVH

// same-cycle implication, skipped while in reset
`define SWA_CHECK_IMP(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, skipped while in reset
`define SWA_CHECK_NXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/swa_pkg.sv
// shared types and constants of the sliding window average core
// no dependencies
`default_nettype none

package swa_pkg;

  // field widths
  localparam int DATA_W         = 32;
  localparam int WSIZE_W        = 9;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int QCNT_W         = $clog2(DATA_W + 1);
  localparam int DEF_MAX_WINDOW = 256;

  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 9'd256;

  // register index (word address bit)
  localparam logic REG_WINDOW_SIZE = 1'b0;

  // request kinds
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  // commands from the sequencer to the window store
  typedef struct packed {
    logic capture;
    logic add;
    logic empty;
  } win_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/sliding_window_average_core.sv
// channel | dir | handshake          | payload
// in_     | in  | in_tvalid/tready   | tuser: func; tdata: arrival_time, waiting_time
// out_    | out | out_tvalid/tready  | tdata: avg_waiting, avg_arrival, fill_count
// cfg_    | in  | psel/penable/pready| window_size at byte address 0
//
// an item goes from accept through the update, the divider load, the two bit-serial
// dividers side by side, a check that both have finished and the load of the output
// register; the next request is taken only back in idle, so one item at a time.
// reset is synchronous active low and empties the window, window_size back to 256.
// a stalled output holds its result; the next item is computed and waits in the
// done state, with in_tready low until the output register frees up.
// depends on swa_pkg, swa_win, swa_div and the assertion macro header
`default_nettype none
`include "sliding_window_average_core_defines.svh"

module sliding_window_average_core #(
  parameter int MAX_WINDOW = swa_pkg::DEF_MAX_WINDOW
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // tuser: func
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  input  wire logic                                  in_tuser,
  // tdata: arrival_time [31:0], waiting_time [63:32]
  input  wire logic [2*swa_pkg::DATA_W-1:0]          in_tdata,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // tdata: avg_waiting, avg_arrival, fill_count, zero pad to bytes
  output logic [((2*swa_pkg::DATA_W+$clog2(MAX_WINDOW+1)+7)/8)*8-1:0] out_tdata,
  input  wire logic                                  cfg_psel,
  input  wire logic                                  cfg_penable,
  input  wire logic                                  cfg_pwrite,
  input  wire logic [swa_pkg::CFG_ADDR_W-1:0]        cfg_paddr,
  input  wire logic [swa_pkg::CFG_DATA_W-1:0]        cfg_pwdata,
  output logic [swa_pkg::CFG_DATA_W-1:0]             cfg_prdata,
  output logic                                       cfg_pready
);
  import swa_pkg::*;

  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SLOT_W = $clog2(MAX_WINDOW);
  localparam int SUM_W  = DATA_W + SLOT_W;
  localparam int OUT_W  = ((2 * DATA_W + CNT_W + 7) / 8) * 8;

  state_t            state_r, state_nxt;
  logic              func_r;
  logic [WSIZE_W-1:0] wsize_r;
  logic              cfg_wr;
  logic              accept;
  logic              out_load;
  logic              div_start;
  logic              busy_w, busy_a, div_busy;
  logic [DATA_W-1:0] q_wait, q_arr;
  win_cmd_t          win_cmd;
  logic [CNT_W-1:0]  win_count;
  logic [SUM_W-1:0]  arr_total, wait_total;
  logic              out_valid_r;
  logic [DATA_W-1:0] avg_wait_r, avg_arr_r;
  logic [CNT_W-1:0]  fill_r;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == REG_WINDOW_SIZE);
  assign cfg_prdata = (cfg_paddr[2] == REG_WINDOW_SIZE) ? CFG_DATA_W'(wsize_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsize_r <= WSIZE_RESET;
    end else if (cfg_wr) begin
      wsize_r <= cfg_pwdata[WSIZE_W-1:0];
    end
  end

  assign accept    = in_tvalid && in_tready;
  assign div_busy  = busy_w || busy_a;

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt       = state_r;
    in_tready       = 1'b0;
    div_start       = 1'b0;
    out_load        = 1'b0;
    win_cmd.capture = 1'b0;
    win_cmd.add     = 1'b0;
    win_cmd.empty   = cfg_wr;
    case (state_r)
      ST_IDLE: begin
        in_tready       = 1'b1;
        win_cmd.capture = in_tvalid;
        if (in_tvalid) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (func_r == FUNC_CLEAR) begin
          win_cmd.empty = 1'b1;
        end else begin
          win_cmd.add = 1'b1;
        end
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // request kind held for the update cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_tuser;
    end
  end

  swa_win #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_win (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (win_cmd),
    .window_size   (wsize_r),
    .arrival_in    (in_tdata[DATA_W-1:0]),
    .waiting_in    (in_tdata[2*DATA_W-1:DATA_W]),
    .count         (win_count),
    .arrival_total (arr_total),
    .waiting_total (wait_total)
  );

  // waiting lane
  swa_div #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_div_wait (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (wait_total),
    .divisor  (win_count),
    .busy     (busy_w),
    .quotient (q_wait)
  );

  // arrival lane
  swa_div #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_div_arr (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (arr_total),
    .divisor  (win_count),
    .busy     (busy_a),
    .quotient (q_arr)
  );

  // output register, empty window reads as zero averages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      avg_wait_r <= (win_count == '0) ? '0 : q_wait;
      avg_arr_r  <= (win_count == '0) ? '0 : q_arr;
      fill_r     <= win_count;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({fill_r, avg_arr_r, avg_wait_r});

  // checks
  `SWA_CHECK_NXT(a_accept_to_update, clk, rst_n, accept, state_r == ST_UPD, "accept did not start an update")
  `SWA_CHECK_IMP(a_div_in_div_state, clk, rst_n, div_busy, state_r == ST_DIV, "divider running outside divide state")
  `SWA_CHECK_IMP(a_lanes_in_step, clk, rst_n, busy_w != busy_a, 1'b0, "divider lanes out of step")
  `SWA_CHECK_IMP(a_empty_is_zero, clk, rst_n, out_valid_r && (fill_r == '0), (avg_wait_r == '0) && (avg_arr_r == '0), "empty window gave nonzero average")

endmodule

`default_nettype wire

// File: rtl/core/swa_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on swa_pkg
`default_nettype none

module swa_div #(
  parameter int MAX_WINDOW = swa_pkg::DEF_MAX_WINDOW
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire logic                                          start,
  input  wire logic [swa_pkg::DATA_W+$clog2(MAX_WINDOW)-1:0] dividend,
  input  wire logic [$clog2(MAX_WINDOW+1)-1:0]               divisor,
  output logic                                               busy,
  output logic [swa_pkg::DATA_W-1:0]                         quotient
);
  import swa_pkg::*;

  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SLOT_W = $clog2(MAX_WINDOW);
  localparam int SUM_W  = DATA_W + SLOT_W;

  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  dsr_r;
  logic [DATA_W-1:0] dvd_r, dvd_nxt;
  logic [QCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic [CNT_W:0]    trial;
  logic              q_bit;

  // one trial subtract per cycle; quotient bits shift in at the bottom
  always_comb begin
    trial = {rem_r, dvd_r[DATA_W-1]};
    q_bit = (trial >= {1'b0, dsr_r});
    if (q_bit) begin
      rem_nxt = CNT_W'(trial - {1'b0, dsr_r});
    end else begin
      rem_nxt = trial[CNT_W-1:0];
    end
    dvd_nxt = {dvd_r[DATA_W-2:0], q_bit};
  end

  // control: bit counter and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= QCNT_W'(DATA_W);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - QCNT_W'(1);
      busy_r <= (cnt_r != QCNT_W'(1));
    end
  end

  // datapath: high part of the total is already below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= CNT_W'(dividend[SUM_W-1:DATA_W]);
      dvd_r <= dividend[DATA_W-1:0];
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = dvd_r;

endmodule

`default_nettype wire

// File: rtl/core/swa_win.sv
// ring buffer of records with running totals and fill count
// depends on swa_pkg
`default_nettype none

module swa_win #(
  parameter int MAX_WINDOW = swa_pkg::DEF_MAX_WINDOW
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire swa_pkg::win_cmd_t                             cmd,
  input  wire logic [swa_pkg::WSIZE_W-1:0]                   window_size,
  input  wire logic [swa_pkg::DATA_W-1:0]                    arrival_in,
  input  wire logic [swa_pkg::DATA_W-1:0]                    waiting_in,
  output logic [$clog2(MAX_WINDOW+1)-1:0]                    count,
  output logic [swa_pkg::DATA_W+$clog2(MAX_WINDOW)-1:0]      arrival_total,
  output logic [swa_pkg::DATA_W+$clog2(MAX_WINDOW)-1:0]      waiting_total
);
  import swa_pkg::*;

  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SLOT_W = $clog2(MAX_WINDOW);
  localparam int SUM_W  = DATA_W + SLOT_W;
  localparam int CMP_W  = (CNT_W > WSIZE_W) ? CNT_W : WSIZE_W;

  logic [DATA_W-1:0] arr_mem [MAX_WINDOW];
  logic [DATA_W-1:0] wait_mem [MAX_WINDOW];

  logic [DATA_W-1:0] arr_in_r, wait_in_r;
  logic [DATA_W-1:0] rd_arr_r, rd_wait_r;
  logic [SLOT_W-1:0] oldest_r, oldest_nxt;
  logic [SLOT_W-1:0] next_r, next_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SUM_W-1:0]  arr_tot_r, arr_tot_nxt;
  logic [SUM_W-1:0]  wait_tot_r, wait_tot_nxt;
  logic [CMP_W-1:0]  ws_ext, eff_ext;
  logic [CNT_W-1:0]  eff;
  logic              full;
  logic [CNT_W-1:0]  oldest_inc, next_inc;
  logic [DATA_W-1:0] ev_arr, ev_wait;

  // effective size: zero acts as one, clamp to the store depth
  always_comb begin
    ws_ext = CMP_W'(window_size);
    if (ws_ext == '0) begin
      eff_ext = CMP_W'(1);
    end else if (ws_ext > CMP_W'(MAX_WINDOW)) begin
      eff_ext = CMP_W'(MAX_WINDOW);
    end else begin
      eff_ext = ws_ext;
    end
    eff = eff_ext[CNT_W-1:0];
  end

  // eviction, slot advance and running totals
  always_comb begin
    full       = (count_r >= eff);
    ev_arr     = full ? rd_arr_r : '0;
    ev_wait    = full ? rd_wait_r : '0;
    oldest_inc = CNT_W'(oldest_r) + CNT_W'(1);
    next_inc   = CNT_W'(next_r) + CNT_W'(1);

    oldest_nxt   = oldest_r;
    next_nxt     = next_r;
    count_nxt    = count_r;
    arr_tot_nxt  = arr_tot_r;
    wait_tot_nxt = wait_tot_r;

    if (cmd.empty) begin
      oldest_nxt   = '0;
      next_nxt     = '0;
      count_nxt    = '0;
      arr_tot_nxt  = '0;
      wait_tot_nxt = '0;
    end else if (cmd.add) begin
      arr_tot_nxt  = arr_tot_r - SUM_W'(ev_arr) + SUM_W'(arr_in_r);
      wait_tot_nxt = wait_tot_r - SUM_W'(ev_wait) + SUM_W'(wait_in_r);
      next_nxt     = (next_inc >= eff) ? '0 : next_inc[SLOT_W-1:0];
      if (full) begin
        oldest_nxt = (oldest_inc >= eff) ? '0 : oldest_inc[SLOT_W-1:0];
      end else begin
        count_nxt  = count_r + CNT_W'(1);
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r   <= '0;
      next_r     <= '0;
      count_r    <= '0;
      arr_tot_r  <= '0;
      wait_tot_r <= '0;
    end else begin
      oldest_r   <= oldest_nxt;
      next_r     <= next_nxt;
      count_r    <= count_nxt;
      arr_tot_r  <= arr_tot_nxt;
      wait_tot_r <= wait_tot_nxt;
    end
  end

  // incoming record held until the update cycle
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      arr_in_r  <= arrival_in;
      wait_in_r <= waiting_in;
    end
  end

  // record store: registered read of the oldest slot, write at the next slot
  always_ff @(posedge clk) begin
    rd_arr_r  <= arr_mem[oldest_r];
    rd_wait_r <= wait_mem[oldest_r];
    if (cmd.add && !cmd.empty) begin
      arr_mem[next_r]  <= arr_in_r;
      wait_mem[next_r] <= wait_in_r;
    end
  end

  assign count         = count_r;
  assign arrival_total = arr_tot_r;
  assign waiting_total = wait_tot_r;

endmodule

`default_nettype wire
